>>> rtl/particle_age_step_defines.svh
// Assertion helpers shared by the particle age step RTL.
`ifndef PARTICLE_AGE_STEP_DEFINES_SVH
`define PARTICLE_AGE_STEP_DEFINES_SVH

// Same-cycle implication, clocked on clock, off during reset.
`define PAE_ASSERT_IMPL(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("particle_age_step: assertion failed");

// Next-cycle implication.
`define PAE_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("particle_age_step: assertion failed");

`endif

>>> rtl/pae_pkg.sv
// ----------------------------------------------------------------------------
// pae_pkg
// Types and constants shared by the particle age step pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package pae_pkg;

   // pipeline layout: 2 front, 8 divide, 2 interpolate, 2 move stages
   localparam int unsigned QUOT_BITS       = 16;
   localparam int unsigned BITS_PER_STAGE  = 2;
   localparam int unsigned NUM_DIV_STAGES  = QUOT_BITS / BITS_PER_STAGE;
   localparam int unsigned NUM_STAGES      = 14;
   localparam int unsigned DIV_FIRST       = 3;
   localparam int unsigned DIV_LAST        = DIV_FIRST + NUM_DIV_STAGES - 1;

   // register indexes
   localparam logic [2:0] CSR_ALPHA_WINDOW = 3'd0;
   localparam logic [2:0] CSR_SPEED_WINDOW = 3'd1;
   localparam logic [2:0] CSR_SCALE_WINDOW = 3'd2;
   localparam logic [2:0] CSR_ALPHA_ENDS   = 3'd3;
   localparam logic [2:0] CSR_SPEED_ENDS   = 3'd4;
   localparam logic [2:0] CSR_SCALE_ENDS   = 3'd5;

   localparam logic [15:0] ALPHA_ENDS_RESET = 16'hFF00;
   localparam logic [31:0] SCALE_ENDS_RESET = 32'h0101_0100;

   // one window's factor in flight: remainder, divisor, quotient so far,
   // and a fixed factor (0 or 1.0) when outside the window
   typedef struct packed {
      logic [23:0] rem;
      logic [23:0] div;
      logic [15:0] quot;
      logic        fix;
      logic        fix_one;
   } div_type;

   // per-particle data that rides along the pipe
   typedef struct packed {
      logic        [23:0] nage;
      logic signed [40:0] prod_x;
      logic signed [40:0] prod_y;
      logic signed [40:0] prod_z;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic        [15:0] base_size;
   } body_type;

endpackage

`default_nettype wire

>>> rtl/pae_front.sv
// ----------------------------------------------------------------------------
// pae_front
// Step clipping, new age, window classification and direction times step.
// ----------------------------------------------------------------------------
`default_nettype none

module pae_front (
   input  wire logic                clock,
   input  wire logic [1:0]          stage_en,
   input  wire logic [23:0]         time_step,
   input  wire logic [23:0]         age,
   input  wire logic [23:0]         life_span,
   input  wire logic signed [31:0]  pos_x,
   input  wire logic signed [31:0]  pos_y,
   input  wire logic signed [31:0]  pos_z,
   input  wire logic signed [15:0]  dir_x,
   input  wire logic signed [15:0]  dir_y,
   input  wire logic signed [15:0]  dir_z,
   input  wire logic [15:0]         base_size,
   input  wire logic [47:0]         alpha_window,
   input  wire logic [47:0]         speed_window,
   input  wire logic [47:0]         scale_window,
   output pae_pkg::div_type         alpha_div,
   output pae_pkg::div_type         speed_div,
   output pae_pkg::div_type         scale_div,
   output pae_pkg::body_type        body
);
   import pae_pkg::*;

   logic signed [24:0] remain;
   logic signed [24:0] step_s;
   logic signed [24:0] dt_in;
   logic [23:0]        nage_in;

   logic signed [24:0] dt_ff;
   logic [23:0]        nage_ff;
   logic signed [31:0] pos_x_ff, pos_y_ff, pos_z_ff;
   logic signed [15:0] dir_x_ff, dir_y_ff, dir_z_ff;
   logic [15:0]        base_ff;

   body_type body_in, body_ff;
   div_type  alpha_in, speed_in, scale_in;
   div_type  alpha_ff, speed_ff, scale_ff;

   function automatic div_type classify(input logic [23:0] na, input logic [47:0] win);
      logic [23:0] s;
      logic [23:0] e;
      div_type     r;
      s         = win[23:0];
      e         = win[47:24];
      r.div     = e - s;
      r.rem     = '0;
      r.quot    = '0;
      r.fix     = 1'b1;
      r.fix_one = 1'b0;
      if (e <= s) begin
         r.fix_one = (na >= s);
      end else if (na <= s) begin
         r.fix_one = 1'b0;
      end else if (na >= e) begin
         r.fix_one = 1'b1;
      end else begin
         r.fix = 1'b0;
         r.rem = na - s;
      end
      return r;
   endfunction

   // stage 1
   always_comb begin
      remain  = $signed({1'b0, life_span}) - $signed({1'b0, age});
      step_s  = $signed({1'b0, time_step});
      if (remain < step_s) begin
         dt_in   = remain;
         nage_in = life_span;
      end else begin
         dt_in   = step_s;
         nage_in = age + time_step;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         dt_ff    <= dt_in;
         nage_ff  <= nage_in;
         pos_x_ff <= pos_x;
         pos_y_ff <= pos_y;
         pos_z_ff <= pos_z;
         dir_x_ff <= dir_x;
         dir_y_ff <= dir_y;
         dir_z_ff <= dir_z;
         base_ff  <= base_size;
      end
   end

   // stage 2
   always_comb begin
      body_in.nage      = nage_ff;
      body_in.prod_x    = 41'(dir_x_ff) * 41'(dt_ff);
      body_in.prod_y    = 41'(dir_y_ff) * 41'(dt_ff);
      body_in.prod_z    = 41'(dir_z_ff) * 41'(dt_ff);
      body_in.pos_x     = pos_x_ff;
      body_in.pos_y     = pos_y_ff;
      body_in.pos_z     = pos_z_ff;
      body_in.base_size = base_ff;
      alpha_in          = classify(nage_ff, alpha_window);
      speed_in          = classify(nage_ff, speed_window);
      scale_in          = classify(nage_ff, scale_window);
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         body_ff  <= body_in;
         alpha_ff <= alpha_in;
         speed_ff <= speed_in;
         scale_ff <= scale_in;
      end
   end

   assign body      = body_ff;
   assign alpha_div = alpha_ff;
   assign speed_div = speed_ff;
   assign scale_div = scale_ff;

endmodule

`default_nettype wire

>>> rtl/pae_div.sv
// ----------------------------------------------------------------------------
// pae_div
// Pipelined restoring divider for one window factor, two quotient bits a stage.
// ----------------------------------------------------------------------------
`default_nettype none

`include "particle_age_step_defines.svh"

module pae_div (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic [pae_pkg::NUM_DIV_STAGES-1:0]      stage_en,
   input  wire logic [pae_pkg::NUM_DIV_STAGES-1:0]      stage_valid,
   input  wire pae_pkg::div_type                        div_in,
   output pae_pkg::div_type                             div_out
);
   import pae_pkg::*;

   div_type stage_ff [NUM_DIV_STAGES];

   function automatic div_type div_step(input div_type x);
      div_type     r;
      logic [24:0] two_rem;
      r = x;
      for (int i = 0; i < BITS_PER_STAGE; i++) begin
         two_rem = {r.rem, 1'b0};
         if (two_rem >= {1'b0, r.div}) begin
            two_rem = two_rem - {1'b0, r.div};
            r.quot  = {r.quot[14:0], 1'b1};
         end else begin
            r.quot  = {r.quot[14:0], 1'b0};
         end
         r.rem = two_rem[23:0];
      end
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         stage_ff[0] <= div_step(div_in);
      end
      for (int k = 1; k < NUM_DIV_STAGES; k++) begin
         if (stage_en[k]) begin
            stage_ff[k] <= div_step(stage_ff[k-1]);
         end
      end
   end

   assign div_out = stage_ff[NUM_DIV_STAGES-1];

   // remainder stays below the divisor inside a window
   `PAE_ASSERT_IMPL(a_rem_below_div,
      stage_valid[NUM_DIV_STAGES-1] && !div_out.fix, div_out.rem < div_out.div)

endmodule

`default_nettype wire

>>> rtl/pae_lerp.sv
// ----------------------------------------------------------------------------
// pae_lerp
// Linear interpolation of alpha, speed and scale by their window factors.
// ----------------------------------------------------------------------------
`default_nettype none

module pae_lerp (
   input  wire logic                clock,
   input  wire logic [1:0]          stage_en,
   input  wire pae_pkg::div_type    alpha_div,
   input  wire pae_pkg::div_type    speed_div,
   input  wire pae_pkg::div_type    scale_div,
   input  wire logic [15:0]         alpha_ends,
   input  wire logic [47:0]         speed_ends,
   input  wire logic [31:0]         scale_ends,
   output logic [7:0]               alpha,
   output logic signed [23:0]       speed,
   output logic [15:0]              scale
);
   import pae_pkg::*;

   logic signed [17:0] ta, tv, ts;
   logic signed [8:0]  diff_a;
   logic signed [24:0] diff_v;
   logic signed [16:0] diff_s;
   logic signed [26:0] pa_in, pa_ff;
   logic signed [42:0] pv_in, pv_ff;
   logic signed [34:0] ps_in, ps_ff;
   logic signed [27:0] sum_a;
   logic signed [43:0] sum_v;
   logic signed [35:0] sum_s;
   logic [7:0]         alpha_ff;
   logic signed [23:0] speed_ff;
   logic [15:0]        scale_ff;

   // factor as Q1.16 in 0..1.0
   function automatic logic signed [17:0] factor(input div_type d);
      logic [16:0] t;
      if (d.fix) begin
         t = d.fix_one ? 17'h1_0000 : 17'h0_0000;
      end else begin
         t = {1'b0, d.quot};
      end
      return $signed({1'b0, t});
   endfunction

   always_comb begin
      ta     = factor(alpha_div);
      tv     = factor(speed_div);
      ts     = factor(scale_div);
      diff_a = $signed({1'b0, alpha_ends[15:8]}) - $signed({1'b0, alpha_ends[7:0]});
      diff_v = 25'($signed(speed_ends[47:24])) - 25'($signed(speed_ends[23:0]));
      diff_s = $signed({1'b0, scale_ends[31:16]}) - $signed({1'b0, scale_ends[15:0]});
      pa_in  = 27'(ta) * 27'(diff_a);
      pv_in  = 43'(tv) * 43'(diff_v);
      ps_in  = 35'(ts) * 35'(diff_s);
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         pa_ff <= pa_in;
         pv_ff <= pv_in;
         ps_ff <= ps_in;
      end
   end

   // start * 1.0 + product, then floor by 2^16
   always_comb begin
      sum_a = (28'($signed({1'b0, alpha_ends[7:0]})) <<< 16) + 28'(pa_ff);
      sum_v = (44'($signed(speed_ends[23:0])) <<< 16) + 44'(pv_ff);
      sum_s = (36'($signed({1'b0, scale_ends[15:0]})) <<< 16) + 36'(ps_ff);
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         alpha_ff <= sum_a[23:16];
         speed_ff <= sum_v[39:16];
         scale_ff <= sum_s[31:16];
      end
   end

   assign alpha = alpha_ff;
   assign speed = speed_ff;
   assign scale = scale_ff;

endmodule

`default_nettype wire

>>> rtl/pae_move.sv
// ----------------------------------------------------------------------------
// pae_move
// Displacement by speed, saturating position update and half extent.
// ----------------------------------------------------------------------------
`default_nettype none

module pae_move (
   input  wire logic                clock,
   input  wire logic [1:0]          stage_en,
   input  wire pae_pkg::body_type   body,
   input  wire logic signed [23:0]  speed,
   input  wire logic [15:0]         scale,
   output logic [23:0]              new_age,
   output logic signed [31:0]       new_pos_x,
   output logic signed [31:0]       new_pos_y,
   output logic signed [31:0]       new_pos_z,
   output logic [15:0]              half_extent
);
   import pae_pkg::*;

   // speed times (dir * dt), split in two partial products per axis
   logic signed [46:0] lo_x_ff, lo_y_ff, lo_z_ff;
   logic signed [44:0] hi_x_ff, hi_y_ff, hi_z_ff;
   logic [31:0]        ext_ff;
   logic [23:0]        nage_ff;
   logic signed [31:0] pos_x_ff, pos_y_ff, pos_z_ff;

   logic [23:0]        ext_shift;
   logic [23:0]        age_out_ff;
   logic signed [31:0] px_out_ff, py_out_ff, pz_out_ff;
   logic [15:0]        ext_out_ff;

   function automatic logic signed [46:0] mul_lo(input logic signed [23:0] s,
                                                 input logic signed [40:0] p);
      logic signed [21:0] l;
      l = $signed({1'b0, p[20:0]});
      return 47'(s) * 47'(l);
   endfunction

   function automatic logic signed [44:0] mul_hi(input logic signed [23:0] s,
                                                 input logic signed [40:0] p);
      logic signed [19:0] h;
      h = $signed(p[40:21]);
      return 45'(s) * 45'(h);
   endfunction

   function automatic logic signed [31:0] advance(input logic signed [31:0] pos,
                                                  input logic signed [44:0] hi,
                                                  input logic signed [46:0] lo);
      logic signed [65:0] tot;
      logic signed [35:0] disp;
      logic signed [36:0] sum;
      logic signed [31:0] r;
      tot  = (66'(hi) <<< 21) + 66'(lo);
      disp = tot[65:30];
      sum  = 37'(pos) + 37'(disp);
      if (sum[36:31] == 6'b000000 || sum[36:31] == 6'b111111) begin
         r = sum[31:0];
      end else if (sum[36]) begin
         r = 32'sh8000_0000;
      end else begin
         r = 32'sh7FFF_FFFF;
      end
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         lo_x_ff  <= mul_lo(speed, body.prod_x);
         lo_y_ff  <= mul_lo(speed, body.prod_y);
         lo_z_ff  <= mul_lo(speed, body.prod_z);
         hi_x_ff  <= mul_hi(speed, body.prod_x);
         hi_y_ff  <= mul_hi(speed, body.prod_y);
         hi_z_ff  <= mul_hi(speed, body.prod_z);
         ext_ff   <= 32'(body.base_size) * 32'(scale);
         nage_ff  <= body.nage;
         pos_x_ff <= body.pos_x;
         pos_y_ff <= body.pos_y;
         pos_z_ff <= body.pos_z;
      end
   end

   assign ext_shift = ext_ff[31:8];

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         age_out_ff <= nage_ff;
         px_out_ff  <= advance(pos_x_ff, hi_x_ff, lo_x_ff);
         py_out_ff  <= advance(pos_y_ff, hi_y_ff, lo_y_ff);
         pz_out_ff  <= advance(pos_z_ff, hi_z_ff, lo_z_ff);
         ext_out_ff <= (|ext_shift[23:16]) ? 16'hFFFF : ext_shift[15:0];
      end
   end

   assign new_age     = age_out_ff;
   assign new_pos_x   = px_out_ff;
   assign new_pos_y   = py_out_ff;
   assign new_pos_z   = pz_out_ff;
   assign half_extent = ext_out_ff;

endmodule

`default_nettype wire

>>> rtl/particle_age_step.sv
// One particle update per transfer. The pipeline is 14 stages deep, and a new
// item is taken every cycle while req_ready is high. The depth is set by the
// three window factor dividers, which retire two quotient bits a stage over
// eight stages. A stage holds its item only while the stage after it is full
// and stalled, so req_ready stays high as long as any bubble remains in the
// pipe. The csr_ channel is always ready; registers must only be written
// while no item is in flight.
// ----------------------------------------------------------------------------
// particle_age_step
// Age, position, alpha and size update for one particle per cycle while req_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

`include "particle_age_step_defines.svh"

module particle_age_step (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [2:0]          csr_index,
   input  wire logic [47:0]         csr_data,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [23:0]         req_time_step,
   input  wire logic [23:0]         req_age,
   input  wire logic [23:0]         req_life_span,
   input  wire logic signed [31:0]  req_pos_x,
   input  wire logic signed [31:0]  req_pos_y,
   input  wire logic signed [31:0]  req_pos_z,
   input  wire logic signed [15:0]  req_dir_x,
   input  wire logic signed [15:0]  req_dir_y,
   input  wire logic signed [15:0]  req_dir_z,
   input  wire logic [15:0]         req_base_size,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [23:0]              rsp_new_age,
   output logic signed [31:0]       rsp_new_pos_x,
   output logic signed [31:0]       rsp_new_pos_y,
   output logic signed [31:0]       rsp_new_pos_z,
   output logic [7:0]               rsp_alpha,
   output logic [15:0]              rsp_half_extent
);
   import pae_pkg::*;

   logic [47:0] alpha_window_ff, speed_window_ff, scale_window_ff;
   logic [15:0] alpha_ends_ff;
   logic [47:0] speed_ends_ff;
   logic [31:0] scale_ends_ff;

   logic [NUM_STAGES:1]   valid_ff;
   logic [NUM_STAGES:1]   valid_in;
   logic [NUM_STAGES+1:1] adv;

   div_type  alpha_s2, speed_s2, scale_s2;
   div_type  alpha_dv, speed_dv, scale_dv;
   body_type body_s2;
   body_type body_ff [DIV_FIRST:DIV_LAST+2];

   logic [7:0]         alpha_l;
   logic signed [23:0] speed_l;
   logic [15:0]        scale_l;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_window_ff <= '0;
         speed_window_ff <= '0;
         scale_window_ff <= '0;
         alpha_ends_ff   <= ALPHA_ENDS_RESET;
         speed_ends_ff   <= '0;
         scale_ends_ff   <= SCALE_ENDS_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ALPHA_WINDOW: alpha_window_ff <= csr_data;
            CSR_SPEED_WINDOW: speed_window_ff <= csr_data;
            CSR_SCALE_WINDOW: scale_window_ff <= csr_data;
            CSR_ALPHA_ENDS:   alpha_ends_ff   <= csr_data[15:0];
            CSR_SPEED_ENDS:   speed_ends_ff   <= csr_data;
            CSR_SCALE_ENDS:   scale_ends_ff   <= csr_data[31:0];
            default: ;
         endcase
      end
   end

   // a stage loads when it is empty or its content moves on
   always_comb begin
      adv[NUM_STAGES+1] = rsp_ready;
      for (int k = NUM_STAGES; k >= 1; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
      valid_in[1] = req_valid;
      for (int k = 2; k <= NUM_STAGES; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 1; k <= NUM_STAGES; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   assign req_ready = adv[1];

   pae_front u_front (
      .clock        (clock),
      .stage_en     (adv[2:1]),
      .time_step    (req_time_step),
      .age          (req_age),
      .life_span    (req_life_span),
      .pos_x        (req_pos_x),
      .pos_y        (req_pos_y),
      .pos_z        (req_pos_z),
      .dir_x        (req_dir_x),
      .dir_y        (req_dir_y),
      .dir_z        (req_dir_z),
      .base_size    (req_base_size),
      .alpha_window (alpha_window_ff),
      .speed_window (speed_window_ff),
      .scale_window (scale_window_ff),
      .alpha_div    (alpha_s2),
      .speed_div    (speed_s2),
      .scale_div    (scale_s2),
      .body         (body_s2)
   );

   pae_div u_div_alpha (
      .clock       (clock),
      .reset       (reset),
      .stage_en    (adv[DIV_LAST:DIV_FIRST]),
      .stage_valid (valid_ff[DIV_LAST:DIV_FIRST]),
      .div_in      (alpha_s2),
      .div_out     (alpha_dv)
   );

   pae_div u_div_speed (
      .clock       (clock),
      .reset       (reset),
      .stage_en    (adv[DIV_LAST:DIV_FIRST]),
      .stage_valid (valid_ff[DIV_LAST:DIV_FIRST]),
      .div_in      (speed_s2),
      .div_out     (speed_dv)
   );

   pae_div u_div_scale (
      .clock       (clock),
      .reset       (reset),
      .stage_en    (adv[DIV_LAST:DIV_FIRST]),
      .stage_valid (valid_ff[DIV_LAST:DIV_FIRST]),
      .div_in      (scale_s2),
      .div_out     (scale_dv)
   );

   // particle data alongside the divider and interpolation stages
   always_ff @(posedge clock) begin
      if (adv[DIV_FIRST]) begin
         body_ff[DIV_FIRST] <= body_s2;
      end
      for (int k = DIV_FIRST + 1; k <= DIV_LAST + 2; k++) begin
         if (adv[k]) begin
            body_ff[k] <= body_ff[k-1];
         end
      end
   end

   pae_lerp u_lerp (
      .clock      (clock),
      .stage_en   (adv[DIV_LAST+2:DIV_LAST+1]),
      .alpha_div  (alpha_dv),
      .speed_div  (speed_dv),
      .scale_div  (scale_dv),
      .alpha_ends (alpha_ends_ff),
      .speed_ends (speed_ends_ff),
      .scale_ends (scale_ends_ff),
      .alpha      (alpha_l),
      .speed      (speed_l),
      .scale      (scale_l)
   );

   pae_move u_move (
      .clock       (clock),
      .stage_en    (adv[NUM_STAGES:NUM_STAGES-1]),
      .body        (body_ff[DIV_LAST+2]),
      .speed       (speed_l),
      .scale       (scale_l),
      .new_age     (rsp_new_age),
      .new_pos_x   (rsp_new_pos_x),
      .new_pos_y   (rsp_new_pos_y),
      .new_pos_z   (rsp_new_pos_z),
      .half_extent (rsp_half_extent)
   );

   // alpha byte is ready early, at the interpolation output; hold it in line with the rest
   logic [7:0] alpha_d1_ff, alpha_d2_ff;

   always_ff @(posedge clock) begin
      if (adv[NUM_STAGES-1]) begin
         alpha_d1_ff <= alpha_l;
      end
      if (adv[NUM_STAGES]) begin
         alpha_d2_ff <= alpha_d1_ff;
      end
   end

   assign rsp_alpha = alpha_d2_ff;
   assign rsp_valid = valid_ff[NUM_STAGES];

   // input side only backs up once every stage is full and the output stalls
   `PAE_ASSERT_IMPL(a_ready_only_full, !req_ready, (&valid_ff) && !rsp_ready)
   // a draining output pulls the next item into the last stage
   `PAE_ASSERT_NEXT(a_drain_refill, valid_ff[NUM_STAGES-1] && rsp_ready,
      valid_ff[NUM_STAGES])

endmodule

`default_nettype wire
